>>> hw/rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the q24.8 fixed-point alu
// no dependencies
package fpa_pkg;

    localparam int DataW       = 32;
    localparam int FracBitsDef = 8;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } opcode_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [DataW-1:0]  operand_a;
        logic signed [DataW-1:0]  operand_b;
    } alu_in_t;

    typedef struct packed {
        logic signed [DataW-1:0]  result;
        logic                     div_by_zero;
    } alu_out_t;

endpackage

>>> hw/rtl/fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
// path: request register, stage 1 register, divider stages, final stage register, output register
// throughput: one request per cycle while no skid entry is held, every opcode takes the same path through the pipeline
// the depth is set by the restoring divider, one quotient bit per stage over 32 + FRAC_BITS stages
// an output register plus one skid entry decouple m_ready from s_ready; stalls freeze the pipeline
// reset (aresetn, synchronous, active low) clears all valid bits; payload registers are not reset
// fixed-point alu top level, depends on fpa_pkg
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = fpa_pkg::FracBitsDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpa_pkg::alu_in_t   s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output fpa_pkg::alu_out_t  m_payload
);

    localparam int DataW = fpa_pkg::DataW;
    localparam int NumW  = DataW + FRAC_BITS;

    logic adv;

    // stage 0: request register
    logic              v0_reg;
    fpa_pkg::alu_in_t  in0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in0_reg <= s_payload;
        end
    end

    // stage 1: simple ops, multiplier, divider operand prep
    logic signed [DataW-1:0]   a_s;
    logic signed [DataW-1:0]   b_s;
    logic [DataW-1:0]          a_u;
    logic [DataW-1:0]          b_u;
    logic [DataW-1:0]          a_mag;
    logic [DataW-1:0]          b_mag;
    logic signed [DataW-1:0]   sum_c;
    logic signed [DataW-1:0]   diff_c;
    logic signed [2*DataW-1:0] prod_c;
    logic                      lt_c;
    logic                      eq_c;
    logic                      gt_c;
    logic [DataW-1:0]          simple_c;

    assign a_s    = in0_reg.operand_a;
    assign b_s    = in0_reg.operand_b;
    assign a_u    = in0_reg.operand_a;
    assign b_u    = in0_reg.operand_b;
    assign a_mag  = a_u[DataW-1] ? (~a_u + {{(DataW-1){1'b0}}, 1'b1}) : a_u;
    assign b_mag  = b_u[DataW-1] ? (~b_u + {{(DataW-1){1'b0}}, 1'b1}) : b_u;
    assign sum_c  = a_s + b_s;
    assign diff_c = a_s - b_s;
    assign prod_c = (2*DataW)'(a_s) * (2*DataW)'(b_s);
    assign lt_c   = a_s < b_s;
    assign eq_c   = a_u == b_u;
    assign gt_c   = !lt_c && !eq_c;

    always_comb begin
        case (in0_reg.opcode)
            fpa_pkg::OP_ADD:      simple_c = sum_c;
            fpa_pkg::OP_SUB:      simple_c = diff_c;
            fpa_pkg::OP_GT:       simple_c = {{(DataW-1){1'b0}}, gt_c};
            fpa_pkg::OP_LT:       simple_c = {{(DataW-1){1'b0}}, lt_c};
            fpa_pkg::OP_GE:       simple_c = {{(DataW-1){1'b0}}, !lt_c};
            fpa_pkg::OP_LE:       simple_c = {{(DataW-1){1'b0}}, lt_c || eq_c};
            fpa_pkg::OP_EQ:       simple_c = {{(DataW-1){1'b0}}, eq_c};
            fpa_pkg::OP_NE:       simple_c = {{(DataW-1){1'b0}}, !eq_c};
            fpa_pkg::OP_MIN:      simple_c = lt_c ? a_u : b_u;
            fpa_pkg::OP_MAX:      simple_c = gt_c ? a_u : b_u;
            fpa_pkg::OP_INC:      simple_c = a_u + {{(DataW-1){1'b0}}, 1'b1};
            fpa_pkg::OP_DEC:      simple_c = a_u - {{(DataW-1){1'b0}}, 1'b1};
            fpa_pkg::OP_FROM_INT: simple_c = a_s <<< FRAC_BITS;
            fpa_pkg::OP_TO_INT:   simple_c = a_s >>> FRAC_BITS;
            default:              simple_c = '0;
        endcase
    end

    logic                      v1_reg;
    logic                      mul1_reg;
    logic                      div1_reg;
    logic [DataW-1:0]          simple1_reg;
    logic signed [2*DataW-1:0] prod1_reg;
    logic [NumW-1:0]           num1_reg;
    logic [DataW-1:0]          den1_reg;
    logic                      neg1_reg;
    logic                      dz1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul1_reg    <= in0_reg.opcode == fpa_pkg::OP_MUL;
            div1_reg    <= in0_reg.opcode == fpa_pkg::OP_DIV;
            simple1_reg <= simple_c;
            prod1_reg   <= prod_c;
            num1_reg    <= {a_mag, {FRAC_BITS{1'b0}}};
            den1_reg    <= b_mag;
            neg1_reg    <= a_u[DataW-1] ^ b_u[DataW-1];
            dz1_reg     <= b_u == '0;
        end
    end

    // restoring divider: one quotient bit per stage; non-divide results ride along
    logic             step_v_reg   [NumW];
    logic [DataW-1:0] step_rem_reg [NumW];
    logic [NumW-1:0]  step_quo_reg [NumW];
    logic [DataW-1:0] step_den_reg [NumW];
    logic             step_neg_reg [NumW];
    logic             step_dz_reg  [NumW];
    logic             step_div_reg [NumW];
    logic [DataW-1:0] step_res_reg [NumW];

    logic             step_v_in    [NumW];
    logic [DataW-1:0] step_rem_in  [NumW];
    logic [NumW-1:0]  step_quo_in  [NumW];
    logic [DataW-1:0] step_den_in  [NumW];
    logic             step_neg_in  [NumW];
    logic             step_dz_in   [NumW];
    logic             step_div_in  [NumW];
    logic [DataW-1:0] step_res_in  [NumW];

    for (genvar g = 0; g < NumW; g++) begin : g_step
        logic [DataW:0]   shifted;
        logic [DataW:0]   trial;
        logic [DataW-1:0] rem_next;
        logic [NumW-1:0]  quo_next;

        if (g == 0) begin : g_first
            assign step_v_in[g]   = v1_reg;
            assign step_rem_in[g] = '0;
            assign step_quo_in[g] = num1_reg;
            assign step_den_in[g] = den1_reg;
            assign step_neg_in[g] = neg1_reg;
            assign step_dz_in[g]  = dz1_reg;
            assign step_div_in[g] = div1_reg;
            // multiply result: arithmetic shift of the full product, low word kept
            assign step_res_in[g] = mul1_reg ? prod1_reg[FRAC_BITS +: DataW] : simple1_reg;
        end else begin : g_next
            assign step_v_in[g]   = step_v_reg[g-1];
            assign step_rem_in[g] = step_rem_reg[g-1];
            assign step_quo_in[g] = step_quo_reg[g-1];
            assign step_den_in[g] = step_den_reg[g-1];
            assign step_neg_in[g] = step_neg_reg[g-1];
            assign step_dz_in[g]  = step_dz_reg[g-1];
            assign step_div_in[g] = step_div_reg[g-1];
            assign step_res_in[g] = step_res_reg[g-1];
        end

        assign shifted = {step_rem_in[g], step_quo_in[g][NumW-1]};
        assign trial   = shifted - {1'b0, step_den_in[g]};

        always_comb begin
            if (!trial[DataW]) begin
                rem_next = trial[DataW-1:0];
                quo_next = {step_quo_in[g][NumW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DataW-1:0];
                quo_next = {step_quo_in[g][NumW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                step_v_reg[g] <= 1'b0;
            end else if (adv) begin
                step_v_reg[g] <= step_v_in[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                step_rem_reg[g] <= rem_next;
                step_quo_reg[g] <= quo_next;
                step_den_reg[g] <= step_den_in[g];
                step_neg_reg[g] <= step_neg_in[g];
                step_dz_reg[g]  <= step_dz_in[g];
                step_div_reg[g] <= step_div_in[g];
                step_res_reg[g] <= step_res_in[g];
            end
        end
    end

    // final stage: quotient sign fix and result select
    logic [DataW-1:0]  q_low;
    logic [DataW-1:0]  div_res;
    fpa_pkg::alu_out_t fin_next;
    logic              vfin_reg;
    fpa_pkg::alu_out_t fin_reg;

    assign q_low   = step_quo_reg[NumW-1][DataW-1:0];
    assign div_res = step_dz_reg[NumW-1]  ? '0 :
                     step_neg_reg[NumW-1] ? (~q_low + {{(DataW-1){1'b0}}, 1'b1}) : q_low;

    always_comb begin
        fin_next.result      = step_div_reg[NumW-1] ? div_res : step_res_reg[NumW-1];
        fin_next.div_by_zero = step_div_reg[NumW-1] && step_dz_reg[NumW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vfin_reg <= 1'b0;
        end else if (adv) begin
            vfin_reg <= step_v_reg[NumW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fin_reg <= fin_next;
        end
    end

    // output register and skid entry
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    fpa_pkg::alu_out_t out_reg;
    fpa_pkg::alu_out_t out_next;
    fpa_pkg::alu_out_t skid_reg;
    logic              load_out;
    logic              load_skid;

    assign adv = !skid_valid_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_next        = fin_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                load_out        = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (vfin_reg) begin
            if (!m_valid_reg || m_ready) begin
                load_out     = 1'b1;
                m_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= out_next;
        end
        if (load_skid) begin
            skid_reg <= fin_reg;
        end
    end

    assign s_ready   = adv;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

`ifndef NO_ASSERTIONS
    a_skid_needs_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_fill_on_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    a_freeze_on_full : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> $stable(vfin_reg) && $stable(fin_reg))
        else $error("pipeline moved while skid entry full");

    a_dz_result_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_payload.div_by_zero |-> m_payload.result == '0)
        else $error("divide by zero with nonzero result");
`endif

endmodule

>>> tb/tb_fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
// self-checking testbench for the q24.8 fixed-point alu: directed table then random requests, every result
// checked against its table value or a behavioral predictor; depends on fpa_pkg and fixed_point_alu_q24_8
module tb_fixed_point_alu_q24_8;

    localparam int FracBits    = fpa_pkg::FracBitsDef;
    localparam int RandomCount = 900;
    localparam int PauseAt     = 450;
    localparam int SteadyFrom  = 750;
    localparam int SettleWait  = 60;
    localparam int StallLimit  = 2000;

    typedef struct {
        fpa_pkg::alu_in_t  req;
        fpa_pkg::alu_out_t want;
    } pending_t;

    typedef struct {
        fpa_pkg::alu_in_t  req;
        bit                typed;
        fpa_pkg::alu_out_t want;
    } vec_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    fpa_pkg::alu_in_t  s_payload;
    logic              m_valid;
    logic              m_ready;
    fpa_pkg::alu_out_t m_payload;

    // typed expectation that travels with the request being driven
    logic              note_typed;
    fpa_pkg::alu_out_t note_want;

    pending_t    pending_results[$];
    vec_t        directed_vecs[$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    bit          steady_tail;

    fixed_point_alu_q24_8 #(
        .FRAC_BITS(FracBits)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic fpa_pkg::alu_out_t alu_predict(fpa_pkg::alu_in_t req);
        longint            a64;
        longint            b64;
        longint            wide;
        fpa_pkg::alu_out_t rsp;
        a64 = $signed(req.operand_a);
        b64 = $signed(req.operand_b);
        rsp.result      = '0;
        rsp.div_by_zero = 1'b0;
        case (req.opcode)
            fpa_pkg::OP_ADD: rsp.result = req.operand_a + req.operand_b;
            fpa_pkg::OP_SUB: rsp.result = req.operand_a - req.operand_b;
            fpa_pkg::OP_MUL: begin
                wide       = (a64 * b64) >>> FracBits;
                rsp.result = wide[31:0];
            end
            fpa_pkg::OP_DIV: begin
                if (b64 == 0) begin
                    rsp.div_by_zero = 1'b1;
                end else begin
                    // numerator widened first, quotient truncates toward zero
                    wide       = (a64 <<< FracBits) / b64;
                    rsp.result = wide[31:0];
                end
            end
            fpa_pkg::OP_GT:       rsp.result = 32'(a64 > b64);
            fpa_pkg::OP_LT:       rsp.result = 32'(a64 < b64);
            fpa_pkg::OP_GE:       rsp.result = 32'(a64 >= b64);
            fpa_pkg::OP_LE:       rsp.result = 32'(a64 <= b64);
            fpa_pkg::OP_EQ:       rsp.result = 32'(a64 == b64);
            fpa_pkg::OP_NE:       rsp.result = 32'(a64 != b64);
            fpa_pkg::OP_MIN:      rsp.result = (a64 < b64) ? req.operand_a : req.operand_b;
            fpa_pkg::OP_MAX:      rsp.result = (a64 > b64) ? req.operand_a : req.operand_b;
            fpa_pkg::OP_INC:      rsp.result = req.operand_a + 32'sd1;
            fpa_pkg::OP_DEC:      rsp.result = req.operand_a - 32'sd1;
            fpa_pkg::OP_FROM_INT: rsp.result = req.operand_a << FracBits;
            fpa_pkg::OP_TO_INT: begin
                wide       = a64 >>> FracBits;
                rsp.result = wide[31:0];
            end
            default: rsp.result = 'x;
        endcase
        return rsp;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // request and result bookkeeping, sampled at the rising edge
    always @(posedge aclk) begin
        pending_t          exp_item;
        fpa_pkg::alu_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = note_typed ? note_want : alu_predict(s_payload);
                pending_results.push_back('{req: s_payload, want: want});
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %h dz %b",
                                            m_payload.result, m_payload.div_by_zero));
                end else begin
                    exp_item = pending_results.pop_front();
                    if (m_payload.result !== exp_item.want.result)
                        flag_mismatch($sformatf("%s a %h b %h: result %h, want %h",
                                                exp_item.req.opcode.name(),
                                                exp_item.req.operand_a,
                                                exp_item.req.operand_b,
                                                m_payload.result, exp_item.want.result));
                    if (m_payload.div_by_zero !== exp_item.want.div_by_zero)
                        flag_mismatch($sformatf("%s a %h b %h: div_by_zero %b, want %b",
                                                exp_item.req.opcode.name(),
                                                exp_item.req.operand_a,
                                                exp_item.req.operand_b,
                                                m_payload.div_by_zero,
                                                exp_item.want.div_by_zero));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side backpressure in bursts, stall density changes over time
    initial begin
        int unsigned stall_pct;
        int unsigned cyc;
        m_ready   = 1'b0;
        stall_pct = 0;
        cyc       = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 20;
                    default: stall_pct = 40;
                endcase
            end
            if (!steady_tail && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input fpa_pkg::alu_in_t req, input bit typed,
                                input fpa_pkg::alu_out_t want);
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_payload  <= req;
        note_typed <= typed;
        note_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic sender_gap(input int unsigned n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic vec_t row(fpa_pkg::opcode_t op, logic [31:0] a, logic [31:0] b,
                                 bit typed, logic [31:0] res, logic dz);
        vec_t v;
        v.req   = '{opcode: op, operand_a: a, operand_b: b};
        v.typed = typed;
        v.want  = '{result: res, div_by_zero: dz};
        return v;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h7fff_ffff;
                    default: v = 32'h8000_0000;
                endcase
            end
            1, 2: v = 32'($urandom_range(0, 4095)) - 32'd2048;
            // whole and half values in fixed point
            3: v = (32'($urandom_range(0, 255)) - 32'd128) << (FracBits - 1);
            4: v = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        fpa_pkg::alu_in_t  req;
        fpa_pkg::alu_out_t none;
        int unsigned       gap_pct;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_payload   = '0;
        note_typed  = 1'b0;
        note_want   = '0;
        steady_tail = 1'b0;
        mismatch_count = 0;
        none        = '0;
        gap_pct     = 0;

        directed_vecs.push_back(row(fpa_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, 1,
                                    32'h0000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 1,
                                    32'h8000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, 1,
                                    32'h7fff_ffff, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_MUL, 32'h0000_0100, 32'hffff_ff80, 0, '0, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0000, 1,
                                    32'h0000_0000, 1));
        directed_vecs.push_back(row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000, 1,
                                    32'h0000_0000, 1));
        // most negative over one raw lsb overflows, low word of the quotient is zero
        directed_vecs.push_back(row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001, 1,
                                    32'h0000_0000, 0));
        // negative quotient truncates toward zero
        directed_vecs.push_back(row(fpa_pkg::OP_DIV, 32'hffff_ffff, 32'h0000_0300, 1,
                                    32'h0000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_GT, 32'h8000_0000, 32'h7fff_ffff, 1,
                                    32'h0000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff, 1,
                                    32'h0000_0001, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_GE, 32'h0000_0005, 32'h0000_0005, 1,
                                    32'h0000_0001, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_LE, 32'h7fff_ffff, 32'h8000_0000, 1,
                                    32'h0000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000, 1,
                                    32'h0000_0001, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_NE, 32'h0000_0000, 32'hffff_ffff, 1,
                                    32'h0000_0001, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_MIN, 32'h7fff_ffff, 32'h8000_0000, 1,
                                    32'h8000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_MAX, 32'h7fff_ffff, 32'h8000_0000, 1,
                                    32'h7fff_ffff, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_MIN, 32'h0000_0003, 32'h0000_0003, 1,
                                    32'h0000_0003, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'h1234_5678, 1,
                                    32'h8000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_DEC, 32'h8000_0000, 32'hffff_ffff, 1,
                                    32'h7fff_ffff, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'hffff_ffff, 1,
                                    32'h8000_0000, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_FROM_INT, 32'hffff_ffff, 32'h0, 1,
                                    32'hffff_ff00, 0));
        // to_int rounds toward minus infinity
        directed_vecs.push_back(row(fpa_pkg::OP_TO_INT, 32'hffff_ffff, 32'h0, 1,
                                    32'hffff_ffff, 0));
        directed_vecs.push_back(row(fpa_pkg::OP_TO_INT, 32'h8000_0000, 32'h7fff_ffff, 1,
                                    32'hff80_0000, 0));

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_vecs[i]) begin
            send_request(directed_vecs[i].req, directed_vecs[i].typed, directed_vecs[i].want);
            if ($urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 8));
        end

        for (int n = 0; n < RandomCount; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 30;
                endcase
            end
            if (n == PauseAt) begin
                // hold off until the pipeline has fully drained
                @(negedge aclk);
                s_valid <= 1'b0;
                wait (pending_results.size() == 0);
            end
            if (n == SteadyFrom)
                steady_tail = 1'b1;
            req.opcode    = fpa_pkg::opcode_t'($urandom_range(0, 15));
            req.operand_a = pick_operand();
            req.operand_b = pick_operand();
            if (req.opcode == fpa_pkg::OP_DIV && $urandom_range(0, 7) == 0)
                req.operand_b = '0;
            if (req.opcode >= fpa_pkg::OP_GT && req.opcode <= fpa_pkg::OP_MAX &&
                $urandom_range(0, 4) == 0)
                req.operand_b = req.operand_a;
            if (!steady_tail && $urandom_range(0, 99) < gap_pct)
                sender_gap($urandom_range(1, 8));
            send_request(req, 1'b0, none);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SettleWait) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/fpa_pkg.sv
hw/rtl/fixed_point_alu_q24_8.sv
tb/tb_fixed_point_alu_q24_8.sv
